// ===== hw/rtl/fwrl_pkg.sv =====
// ----------------------------------------------------------------------------
// fwrl_pkg
// shared types and constants of the fifo reader-writer lock arbiter
// ----------------------------------------------------------------------------
package fwrl_pkg;

  localparam int unsigned IdW      = 4;
  localparam int unsigned NumIds   = 16;
  localparam int unsigned EntryW   = IdW + 1;
  localparam int unsigned DefReqs  = 16;

  typedef enum logic [2:0] {
    ACT_ACQ_S = 3'd0,
    ACT_ACQ_X = 3'd1,
    ACT_REL_S = 3'd2,
    ACT_REL_X = 3'd3,
    ACT_ABORT = 3'd4
  } action_e;

  typedef enum logic [2:0] {
    OC_GRANT_S  = 3'd0,
    OC_GRANT_X  = 3'd1,
    OC_QUEUED   = 3'd2,
    OC_FAILED   = 3'd3,
    OC_RELEASED = 3'd4,
    OC_NOT_HELD = 3'd5,
    OC_ABORT    = 3'd6
  } outcome_e;

  typedef struct packed {
    logic [IdW-1:0] who;
    outcome_e       outcome;
  } result_t;

endpackage

// ===== hw/rtl/fwrl_wait_mem.sv =====
// ----------------------------------------------------------------------------
// fwrl_wait_mem
// wait queue storage, one write and one registered read port
// ----------------------------------------------------------------------------
module fwrl_wait_mem import fwrl_pkg::*; #(
  parameter int unsigned REQUESTERS = DefReqs,
  localparam int unsigned QW = (REQUESTERS > 1) ? $clog2(REQUESTERS) : 1
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [QW-1:0]     waddr_i,
  input  logic [EntryW-1:0] wdata_i,
  input  logic              re_i,
  input  logic [QW-1:0]     raddr_i,
  output logic [EntryW-1:0] rdata_o
);

  logic [EntryW-1:0] mem_q [REQUESTERS];
  logic [EntryW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hw/rtl/fifo_reader_writer_lock.sv =====
// ----------------------------------------------------------------------------
// fifo_reader_writer_lock
// fifo reader-writer lock arbiter with upgrade, wait queue kept in memory
// ----------------------------------------------------------------------------
// channel  dir  fields (lsb first)              notes
// s_axis   in   tdata: action[2:0] requester[6:3] one request item
// m_axis   out  tdata: who[3:0] outcome[6:4]    tlast on final result of item
//
// a request that gives one result is decided in the idle state, its result registered.
// a release walks the queue: each waiter examined takes a memory read, then an
// evaluate step; a further read step when the walk runs dry, then a flush step.
// reset clears all flags and counts; the queue memory needs no clearing.
// a stalled output holds the walk; a new item is taken only when idle.
// ----------------------------------------------------------------------------
module fifo_reader_writer_lock import fwrl_pkg::*; #(
  parameter int unsigned REQUESTERS = DefReqs
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // action[2:0] requester[6:3]
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,   // who[3:0] outcome[6:4]
  output logic       m_axis_tlast
);

  localparam int unsigned QW = (REQUESTERS > 1) ? $clog2(REQUESTERS) : 1;
  localparam int unsigned CW = $clog2(REQUESTERS + 1);

  typedef enum logic [1:0] {S_IDLE, S_READ, S_EVAL, S_FLUSH} state_e;
  typedef enum logic [2:0] {
    K_NONE, K_UPGRADE, K_PUSH, K_CLR_ABORT, K_GRANT, K_RELEASE, K_MARK
  } kind_e;
  typedef enum logic [2:0] {E_SKIP, E_FAIL, E_GX_FREE, E_GX_UP, E_GS, E_STOP} ekind_e;

  state_e            state_q;
  logic [CW-1:0]     sh_q;
  logic              excl_q;
  logic [NumIds-1:0] holds_q, abort_q, waiting_q;
  logic [QW-1:0]     head_q;
  logic [CW-1:0]     count_q;
  result_t           pend_q, out_q;
  logic              out_valid_q, out_last_q;

  logic [2:0]     act;
  logic [IdW-1:0] rq;
  logic           in_range, x, held, slot_free, accept;
  kind_e          i_kind;
  outcome_e       i_oc;
  logic           i_front;

  logic [EntryW-1:0] rdata;
  logic [IdW-1:0]    ep;
  logic              ex;
  ekind_e            e_kind;

  logic [QW:0]   tail_sum;
  logic [QW-1:0] tail_idx, front_idx, head_inc, waddr;
  logic          mem_we, mem_re;

  assign act       = s_axis_tdata[2:0];
  assign rq        = s_axis_tdata[6:3];
  assign in_range  = 32'(rq) < REQUESTERS;
  assign x         = act[0];
  assign held      = holds_q[rq];
  assign slot_free = !out_valid_q || m_axis_tready;
  assign s_axis_tready = (state_q == S_IDLE) && slot_free;
  assign accept    = s_axis_tvalid && s_axis_tready;

  assign tail_sum  = (QW+1)'(head_q) + (QW+1)'(count_q);
  assign tail_idx  = (tail_sum >= (QW+1)'(REQUESTERS)) ?
                     QW'(tail_sum - (QW+1)'(REQUESTERS)) : QW'(tail_sum);
  assign front_idx = (head_q == '0) ? QW'(REQUESTERS - 1) : head_q - QW'(1);
  assign head_inc  = (head_q == QW'(REQUESTERS - 1)) ? '0 : head_q + QW'(1);

  always_comb begin
    i_kind  = K_NONE;
    i_oc    = OC_NOT_HELD;
    i_front = 1'b0;
    if (in_range) begin
      case (act)
        ACT_ACQ_S, ACT_ACQ_X: begin
          if (held && (excl_q || !x)) begin
            i_oc = excl_q ? OC_GRANT_X : OC_GRANT_S;
          end else if (waiting_q[rq]) begin
            i_oc = OC_QUEUED;
          end else if (x && sh_q == CW'(1) && held) begin
            i_kind = K_UPGRADE;
            i_oc   = OC_GRANT_X;
          end else if (count_q != '0 || excl_q || (x && sh_q != '0)) begin
            i_oc    = OC_QUEUED;
            i_front = x && held;
            if (32'(count_q) < REQUESTERS) begin
              i_kind = K_PUSH;
            end
          end else if (abort_q[rq]) begin
            i_kind = K_CLR_ABORT;
            i_oc   = OC_FAILED;
          end else begin
            i_kind = K_GRANT;
            i_oc   = x ? OC_GRANT_X : OC_GRANT_S;
          end
        end
        ACT_REL_S, ACT_REL_X: begin
          if (held && (excl_q ? x : !x)) begin
            i_kind = K_RELEASE;
            i_oc   = OC_RELEASED;
          end
        end
        ACT_ABORT: begin
          i_kind = K_MARK;
          i_oc   = OC_ABORT;
        end
        default: begin
          i_kind = K_NONE;
        end
      endcase
    end
  end

  assign ep = rdata[IdW-1:0];
  assign ex = rdata[EntryW-1];

  always_comb begin
    if (32'(ep) >= REQUESTERS) begin
      e_kind = E_SKIP;
    end else if (abort_q[ep]) begin
      e_kind = E_FAIL;
    end else if (ex) begin
      if (sh_q == '0) begin
        e_kind = E_GX_FREE;
      end else if (sh_q == CW'(1) && holds_q[ep]) begin
        e_kind = E_GX_UP;
      end else begin
        e_kind = E_STOP;
      end
    end else begin
      e_kind = E_GS;
    end
  end

  assign mem_we = accept && (i_kind == K_PUSH);
  assign waddr  = i_front ? front_idx : tail_idx;
  assign mem_re = (state_q == S_READ) && (count_q != '0) && !excl_q;

  fwrl_wait_mem #(.REQUESTERS(REQUESTERS)) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (waddr),
    .wdata_i ({x, rq}),
    .re_i    (mem_re),
    .raddr_i (head_q),
    .rdata_o (rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      sh_q        <= '0;
      excl_q      <= 1'b0;
      holds_q     <= '0;
      abort_q     <= '0;
      waiting_q   <= '0;
      head_q      <= '0;
      count_q     <= '0;
      pend_q      <= '{who: '0, outcome: OC_NOT_HELD};
      out_q       <= '{who: '0, outcome: OC_NOT_HELD};
      out_valid_q <= 1'b0;
      out_last_q  <= 1'b0;
    end else begin
      if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (accept) begin
            case (i_kind)
              K_UPGRADE: begin
                sh_q   <= '0;
                excl_q <= 1'b1;
              end
              K_PUSH: begin
                waiting_q[rq] <= 1'b1;
                count_q       <= count_q + CW'(1);
                if (i_front) begin
                  head_q <= front_idx;
                end
              end
              K_CLR_ABORT: abort_q[rq] <= 1'b0;
              K_GRANT: begin
                holds_q[rq] <= 1'b1;
                if (x) begin
                  excl_q <= 1'b1;
                end else begin
                  sh_q <= sh_q + CW'(1);
                end
              end
              K_RELEASE: begin
                holds_q[rq] <= 1'b0;
                if (x) begin
                  excl_q <= 1'b0;
                end else if (sh_q != '0) begin
                  sh_q <= sh_q - CW'(1);
                end
              end
              K_MARK: abort_q[rq] <= 1'b1;
              default: ;
            endcase
            if (i_kind == K_RELEASE) begin
              pend_q  <= '{who: rq, outcome: i_oc};
              state_q <= S_READ;
            end else begin
              out_q       <= '{who: rq, outcome: i_oc};
              out_last_q  <= 1'b1;
              out_valid_q <= 1'b1;
            end
          end
        end
        S_READ: begin
          state_q <= mem_re ? S_EVAL : S_FLUSH;
        end
        S_EVAL: begin
          if (e_kind == E_STOP) begin
            state_q <= S_FLUSH;
          end else if (e_kind == E_SKIP) begin
            head_q  <= head_inc;
            count_q <= count_q - CW'(1);
            state_q <= S_READ;
          end else if (slot_free) begin
            head_q        <= head_inc;
            count_q       <= count_q - CW'(1);
            waiting_q[ep] <= 1'b0;
            out_q         <= pend_q;
            out_last_q    <= 1'b0;
            out_valid_q   <= 1'b1;
            pend_q.who    <= ep;
            case (e_kind)
              E_FAIL: begin
                abort_q[ep]    <= 1'b0;
                pend_q.outcome <= OC_FAILED;
              end
              E_GX_FREE: begin
                holds_q[ep]    <= 1'b1;
                excl_q         <= 1'b1;
                pend_q.outcome <= OC_GRANT_X;
              end
              E_GX_UP: begin
                sh_q           <= '0;
                excl_q         <= 1'b1;
                pend_q.outcome <= OC_GRANT_X;
              end
              default: begin
                if (!holds_q[ep]) begin
                  holds_q[ep] <= 1'b1;
                  sh_q        <= sh_q + CW'(1);
                end
                pend_q.outcome <= OC_GRANT_S;
              end
            endcase
            state_q <= S_READ;
          end
        end
        S_FLUSH: begin
          if (slot_free) begin
            out_q       <= pend_q;
            out_last_q  <= 1'b1;
            out_valid_q <= 1'b1;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {1'b0, out_q.outcome, out_q.who};
  assign m_axis_tlast  = out_last_q;

endmodule
